### rtl/kvp_pkg.sv
// Package for the key/value command parser: field structs, enums and sizing constants.
// Depends on nothing; imported by key_value_command_parser.
`timescale 1ns / 1ps
`default_nettype none

package kvp_pkg;

    localparam int MAX_CMDS  = 16;
    localparam int MSG_LIMIT = 255;

    localparam int ADDR_W = (MAX_CMDS > 1) ? $clog2(MAX_CMDS) : 1;
    localparam int CNT_W  = $clog2(MAX_CMDS + 1);
    localparam int KEPT_W = $clog2(MSG_LIMIT + 1);

    localparam int         ACC_W   = 20;
    localparam logic [19:0] ACC_SAT = 20'hFFFFF;
    localparam logic [19:0] ACC_MUL_LIMIT = 20'h19999;
    localparam logic [19:0] VALUE_MAX = 20'd65535;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_B     = 8'h42;

    localparam logic [7:0] PIECE_MIN = 8'd3;
    localparam logic [7:0] PIECE_MAX = 8'd8;
    localparam logic [7:0] PIECE_SAT = 8'd255;

    typedef enum logic [2:0] {
        KIND_STATUS = 3'd0,
        KIND_ES     = 3'd1,
        KIND_CS     = 3'd2,
        KIND_CG     = 3'd3,
        KIND_T      = 3'd4,
        KIND_B      = 3'd5
    } cmd_kind_t;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_KEY   = 3'd1,
        PH_MID   = 3'd2,
        PH_VALUE = 3'd3,
        PH_AFTER = 3'd4
    } parse_phase_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic sign;
        logic neg;
        logic digit;
        logic bad;
    } value_flags_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_message;
    } kvp_in_t;

    typedef struct packed {
        logic [2:0]  cmd_kind;
        logic [15:0] cmd_value;
        logic        msg_status;
        logic [4:0]  cmd_count;
        logic        last_of_run;
    } kvp_out_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
    } cmd_entry_t;

endpackage

`default_nettype wire

### rtl/key_value_command_parser.sv
// Key/value command parser: per-character parsing with a synchronous command store.
// Depends on kvp_pkg.
//
//  channel  | signals                | handshake
//  ---------+------------------------+------------------------------------------
//  item     | item (kvp_in_t)        | taken when start is high and busy is low
//  result   | result (kvp_out_t)     | valid for the one cycle strobe is high
//
// One character is parsed in the cycle it is taken; busy stays low between characters.
// A character with end_of_message raises busy for the read-out: stored commands come
// from the store one per cycle (a registered read plus an output register), and a
// message with N emitted commands gives N + 1 results, the last being a status result.
// Reset clears all message state; the store itself is not cleared, and only entries
// below the emitted count reach the result. The receiver cannot stall the results.
`timescale 1ns / 1ps
`default_nettype none

module key_value_command_parser
    import kvp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire kvp_in_t  item,
    output logic          strobe,
    output kvp_out_t      result
);

    // command store
    cmd_entry_t store_mem [MAX_CMDS];
    cmd_entry_t rd_data_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    cmd_entry_t        wr_data;
    logic [ADDR_W-1:0] rd_addr;

    ctrl_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  stored_count_reg, stored_count_next;
    logic [KEPT_W-1:0] chars_kept_reg, chars_kept_next;
    logic [7:0]        last_char_reg, last_char_next;
    logic              text_ended_reg, text_ended_next;
    logic [7:0]        piece_len_reg, piece_len_next;
    parse_phase_t      phase_reg, phase_next;
    logic [1:0]        key_n_reg, key_n_next;
    logic [7:0]        key_a_reg, key_a_next;
    logic [7:0]        key_b_reg, key_b_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    value_flags_t      flags_reg, flags_next;

    logic [CNT_W-1:0]  emit_cnt_reg, emit_cnt_next;
    logic              emit_bad_reg, emit_bad_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              pend_reg, pend_next;
    logic              strobe_reg, strobe_next;
    kvp_out_t          result_reg, result_next;

    logic              take;
    logic [7:0]        ch;
    cmd_kind_t         key_kind;
    logic              piece_ok;
    logic [ACC_W-1:0]  step_acc;
    value_flags_t      step_flags;
    logic [23:0]       acc_prod;
    logic              is_digit;
    logic              is_ws;
    logic              msg_ok;

    assign take   = start && (state_reg == ST_IDLE);
    assign ch     = item.char_in;
    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    always_comb
    begin
        key_kind = KIND_STATUS;
        if (key_n_reg == 2'd2 && key_a_reg == CH_E && key_b_reg == CH_S)
            key_kind = KIND_ES;
        else if (key_n_reg == 2'd2 && key_a_reg == CH_C && key_b_reg == CH_S)
            key_kind = KIND_CS;
        else if (key_n_reg == 2'd2 && key_a_reg == CH_C && key_b_reg == CH_G)
            key_kind = KIND_CG;
        else if (key_n_reg == 2'd1 && key_a_reg == CH_T)
            key_kind = KIND_T;
        else if (key_n_reg == 2'd1 && key_a_reg == CH_B)
            key_kind = KIND_B;
    end

    assign piece_ok = (piece_len_reg >= PIECE_MIN) && (piece_len_reg <= PIECE_MAX) &&
                      (phase_reg == PH_VALUE || phase_reg == PH_AFTER) &&
                      (key_kind != KIND_STATUS) && !flags_reg.bad && flags_reg.digit;

    // one value character
    assign acc_prod = 24'(acc_reg) * 24'd10 + 24'(ch - CH_ZERO);
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_ws    = ch inside {8'h20, [8'h09:8'h0D]};

    always_comb
    begin
        step_acc   = acc_reg;
        step_flags = flags_reg;
        if (!flags_reg.bad)
        begin
            if (is_digit)
            begin
                if (acc_reg > ACC_MUL_LIMIT || acc_prod > 24'(ACC_SAT))
                    step_acc = ACC_SAT;
                else
                    step_acc = acc_prod[ACC_W-1:0];
                step_flags.digit = 1'b1;
            end
            else if (is_ws && !flags_reg.sign && !flags_reg.digit)
            begin
                step_flags = flags_reg;
            end
            else if ((ch == CH_PLUS || ch == CH_MINUS) && !flags_reg.sign && !flags_reg.digit)
            begin
                step_flags.sign = 1'b1;
                if (ch == CH_MINUS)
                    step_flags.neg = 1'b1;
            end
            else
            begin
                step_flags.bad = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        stored_count_next = stored_count_reg;
        chars_kept_next   = chars_kept_reg;
        last_char_next    = last_char_reg;
        text_ended_next   = text_ended_reg;
        piece_len_next    = piece_len_reg;
        phase_next        = phase_reg;
        key_n_next        = key_n_reg;
        key_a_next        = key_a_reg;
        key_b_next        = key_b_reg;
        acc_next          = acc_reg;
        flags_next        = flags_reg;
        emit_cnt_next     = emit_cnt_reg;
        emit_bad_next     = emit_bad_reg;
        rd_idx_next       = rd_idx_reg;
        pend_next         = 1'b0;
        strobe_next       = 1'b0;
        result_next       = result_reg;
        wr_en             = 1'b0;
        wr_addr           = stored_count_reg[ADDR_W-1:0];
        wr_data.kind      = key_kind;
        wr_data.value     = (flags_reg.neg) ? 16'd0 :
                            (acc_reg > VALUE_MAX) ? 16'hFFFF : acc_reg[15:0];
        rd_addr           = rd_idx_reg[ADDR_W-1:0];
        msg_ok            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (!text_ended_reg)
                    begin
                        if (ch == CH_NUL)
                        begin
                            text_ended_next = 1'b1;
                        end
                        else if (chars_kept_reg < KEPT_W'(MSG_LIMIT))
                        begin
                            chars_kept_next = chars_kept_reg + KEPT_W'(1);
                            last_char_next  = ch;
                            if (ch == CH_SEMI)
                            begin
                                if (piece_len_reg != 8'd0)
                                begin
                                    if (piece_ok && stored_count_reg < CNT_W'(MAX_CMDS))
                                    begin
                                        wr_en             = 1'b1;
                                        stored_count_next = stored_count_reg + CNT_W'(1);
                                    end
                                    piece_len_next = 8'd0;
                                    phase_next     = PH_LEAD;
                                    key_n_next     = 2'd0;
                                    key_a_next     = 8'd0;
                                    key_b_next     = 8'd0;
                                    acc_next       = '0;
                                    flags_next     = '0;
                                end
                            end
                            else
                            begin
                                if (piece_len_reg != PIECE_SAT)
                                    piece_len_next = piece_len_reg + 8'd1;
                                if (ch == CH_COLON)
                                begin
                                    if (phase_reg == PH_KEY)
                                        phase_next = PH_MID;
                                    else if (phase_reg == PH_VALUE)
                                        phase_next = PH_AFTER;
                                end
                                else
                                begin
                                    case (phase_reg)
                                        PH_LEAD, PH_KEY:
                                        begin
                                            phase_next = PH_KEY;
                                            // keep two characters, count saturates at three
                                            if (key_n_reg == 2'd0)
                                            begin
                                                key_n_next = 2'd1;
                                                key_a_next = ch;
                                                key_b_next = 8'd0;
                                            end
                                            else if (key_n_reg == 2'd1)
                                            begin
                                                key_n_next = 2'd2;
                                                key_b_next = ch;
                                            end
                                            else
                                            begin
                                                key_n_next = 2'd3;
                                            end
                                        end
                                        PH_MID, PH_VALUE:
                                        begin
                                            phase_next = PH_VALUE;
                                            acc_next   = step_acc;
                                            flags_next = step_flags;
                                        end
                                        default:
                                        begin
                                            phase_next = phase_reg;
                                        end
                                    endcase
                                end
                            end
                        end
                    end

                    if (item.end_of_message)
                    begin
                        msg_ok        = (chars_kept_next != '0) && (last_char_next == CH_SEMI);
                        emit_cnt_next = msg_ok ? stored_count_next : '0;
                        emit_bad_next = !msg_ok;
                        rd_idx_next   = '0;
                        state_next    = ST_EMIT;
                        // drop the message state
                        stored_count_next = '0;
                        chars_kept_next   = '0;
                        last_char_next    = 8'd0;
                        text_ended_next   = 1'b0;
                        piece_len_next    = 8'd0;
                        phase_next        = PH_LEAD;
                        key_n_next        = 2'd0;
                        key_a_next        = 8'd0;
                        key_b_next        = 8'd0;
                        acc_next          = '0;
                        flags_next        = '0;
                    end
                end
            end

            ST_EMIT:
            begin
                if (rd_idx_reg < emit_cnt_reg)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    pend_next   = 1'b1;
                end
                if (pend_reg)
                begin
                    strobe_next             = 1'b1;
                    result_next.cmd_kind    = rd_data_reg.kind;
                    result_next.cmd_value   = rd_data_reg.value;
                    result_next.msg_status  = 1'b0;
                    result_next.cmd_count   = 5'(emit_cnt_reg);
                    result_next.last_of_run = 1'b0;
                end
                else if (rd_idx_reg == emit_cnt_reg)
                begin
                    strobe_next             = 1'b1;
                    result_next.cmd_kind    = KIND_STATUS;
                    result_next.cmd_value   = 16'd0;
                    result_next.msg_status  = emit_bad_reg;
                    result_next.cmd_count   = 5'(emit_cnt_reg);
                    result_next.last_of_run = 1'b1;
                    state_next              = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= wr_data;
        rd_data_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            stored_count_reg <= '0;
            chars_kept_reg   <= '0;
            last_char_reg    <= 8'd0;
            text_ended_reg   <= 1'b0;
            piece_len_reg    <= 8'd0;
            phase_reg        <= PH_LEAD;
            key_n_reg        <= 2'd0;
            key_a_reg        <= 8'd0;
            key_b_reg        <= 8'd0;
            acc_reg          <= '0;
            flags_reg        <= '0;
            emit_cnt_reg     <= '0;
            emit_bad_reg     <= 1'b0;
            rd_idx_reg       <= '0;
            pend_reg         <= 1'b0;
            strobe_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            stored_count_reg <= stored_count_next;
            chars_kept_reg   <= chars_kept_next;
            last_char_reg    <= last_char_next;
            text_ended_reg   <= text_ended_next;
            piece_len_reg    <= piece_len_next;
            phase_reg        <= phase_next;
            key_n_reg        <= key_n_next;
            key_a_reg        <= key_a_next;
            key_b_reg        <= key_b_next;
            acc_reg          <= acc_next;
            flags_reg        <= flags_next;
            emit_cnt_reg     <= emit_cnt_next;
            emit_bad_reg     <= emit_bad_next;
            rd_idx_reg       <= rd_idx_next;
            pend_reg         <= pend_next;
            strobe_reg       <= strobe_next;
        end
    end

endmodule

`default_nettype wire
